FILE: rtl/nsf_pkg.sv
// Shared types and constants for the NMEA sentence framer.
// No dependencies; every other file of the block imports it.
`default_nettype none

package nsf_pkg;

    localparam int BYTE_W   = 8;
    localparam int MAXPOS_W = 10;
    localparam int POS_W    = 11;
    localparam int CK_W     = 7;

    localparam logic [MAXPOS_W-1:0] MAX_POS_RESET = 10'd400;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2a;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7e;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h46;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2c;

    typedef enum logic [1:0] {
        ST_GARBAGE = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_END     = 2'd2,
        ST_REJECT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_CK1  = 3'd2,
        PH_CK2  = 3'd3,
        PH_CR   = 3'd4,
        PH_LF   = 3'd5
    } phase_t;

endpackage

`default_nettype wire

FILE: rtl/nsf_byte_if.sv
// Raw byte input channel of the NMEA sentence framer.
// Depends on nsf_pkg for the byte width.
`default_nettype none

interface nsf_byte_if
    import nsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/nsf_result_if.sv
// Per-byte result channel of the NMEA sentence framer.
// Depends on nsf_pkg for status_t and field widths.
`default_nettype none

interface nsf_result_if
    import nsf_pkg::*;
();
    logic             valid;
    logic             ready;
    status_t          status;
    logic             restarted;
    logic [POS_W-1:0] sentence_length;
    logic [CK_W-1:0]  checksum;
    logic             is_fp_variant;

    modport source (output valid, output status, output restarted, output sentence_length,
                    output checksum, output is_fp_variant, input ready);
    modport sink   (input valid, input status, input restarted, input sentence_length,
                    input checksum, input is_fp_variant, output ready);
endinterface

`default_nettype wire

FILE: rtl/nsf_cfg_if.sv
// Configuration write channel carrying max_body_position.
// Depends on nsf_pkg for the register width.
`default_nettype none

interface nsf_cfg_if
    import nsf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MAXPOS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/nmea_sentence_framer_core.sv
// NMEA sentence framer top level: framing state machine, checksum check and pipeline.
// Depends on nsf_pkg, nsf_byte_if, nsf_result_if and nsf_cfg_if.
//
// Usage:
//   stream  - raw bytes in, valid/ready; one item per received byte.
//   result  - one item out per byte: status (garbage, accepted, sentence end,
//             rejected), restarted, and on a sentence end its total length,
//             body checksum and the FP variant flag (zero otherwise).
//   cfg     - writes max_body_position; always ready, write only while idle.
// Path: a byte accepted from the stream sits in the input register, and its
//   result is loaded into the result register when the pipeline steps.
// Throughput: one byte per cycle while result.ready is high, set by the framing
//   state update, a single compare-and-select pass between the two pipeline registers.
// Reset: phase goes to hunting for '$', counters clear, max_body_position
//   returns to 400, both pipeline registers empty.
// Stall: while result.ready is low a full result register holds; the input
//   register still fills once, so the stream side stalls one byte later.
`default_nettype none

module nmea_sentence_framer_core
    import nsf_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    nsf_byte_if.sink     stream,
    nsf_result_if.source result,
    nsf_cfg_if.sink      cfg
);

    // Body byte legality: printable, excluding the reserved framing characters.
    function automatic logic body_byte_invalid(input logic [BYTE_W-1:0] b);
        return (b < CH_SPACE) || (b > CH_TILDE) || (b == CH_DOLLAR) ||
               (b == CH_BSLASH) || (b == CH_BANG) || (b == CH_TILDE);
    endfunction

    function automatic logic [BYTE_W-1:0] hex_high(input logic [CK_W-1:0] x);
        return CH_ZERO + {5'd0, x[6:4]};
    endfunction

    function automatic logic [BYTE_W-1:0] hex_low(input logic [CK_W-1:0] x);
        logic [3:0] n;
        n = x[3:0];
        return (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (CH_UPPER_A + {4'd0, n} - 8'd10);
    endfunction

    function automatic logic [BYTE_W-1:0] prefix_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            2'd1:    c = CH_F;
            2'd2:    c = CH_P;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

    // Configuration
    logic [MAXPOS_W-1:0] max_pos_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Result register
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic             out_restarted_reg;
    logic [POS_W-1:0] out_length_reg;
    logic [CK_W-1:0]  out_ck_reg;
    logic             out_fp_reg;

    // Framing state
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CK_W-1:0]  xor_reg, xor_next;
    logic [1:0]       pm_reg, pm_next;
    logic             pok_reg, pok_next;

    // Per-byte outcome
    status_t          st;
    logic             rs;
    logic [POS_W-1:0] len;
    logic [CK_W-1:0]  ck;
    logic             fp;
    logic             rej;
    logic             prefix_hit;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] max_ext;

    logic step;

    // Advance the pipeline when a byte is staged and the result slot is free.
    assign step         = in_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || step;
    assign cfg.ready    = 1'b1;

    assign result.valid           = out_valid_reg;
    assign result.status          = out_status_reg;
    assign result.restarted       = out_restarted_reg;
    assign result.sentence_length = out_length_reg;
    assign result.checksum        = out_ck_reg;
    assign result.is_fp_variant   = out_fp_reg;

    assign pos_inc = pos_reg + 11'd1;
    assign max_ext = {1'b0, max_pos_reg};

    // Positions 1..3 must spell "FP," in order for the variant flag.
    assign prefix_hit = (pos_reg[POS_W-1:2] == '0) && (pos_reg[1:0] != 2'd0) &&
                        (pm_reg == pos_reg[1:0] - 2'd1) &&
                        (in_byte_reg == prefix_char(pos_reg[1:0]));

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        pm_next    = pm_reg;
        pok_next   = pok_reg;
        st         = ST_GARBAGE;
        rs         = 1'b0;
        len        = '0;
        ck         = '0;
        fp         = 1'b0;
        rej        = 1'b0;

        case (phase_reg)
            PH_BODY:
            begin
                if (in_byte_reg == CH_STAR && pos_reg <= max_ext)
                begin
                    phase_next = PH_CK1;
                    pos_next   = pos_inc;
                    st         = ST_ACCEPT;
                end
                else if (body_byte_invalid(in_byte_reg) || pos_reg >= max_ext)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    xor_next = xor_reg ^ in_byte_reg[CK_W-1:0];
                    if (prefix_hit)
                    begin
                        pm_next = pos_reg[1:0];
                        if (pos_reg[1:0] == 2'd3)
                        begin
                            pok_next = 1'b1;
                        end
                    end
                    pos_next = pos_inc;
                    st       = ST_ACCEPT;
                end
            end
            PH_CK1:
            begin
                if (in_byte_reg == hex_high(xor_reg))
                begin
                    phase_next = PH_CK2;
                    pos_next   = pos_inc;
                    st         = ST_ACCEPT;
                end
                else
                begin
                    rej = 1'b1;
                end
            end
            PH_CK2:
            begin
                if (in_byte_reg == hex_low(xor_reg))
                begin
                    phase_next = PH_CR;
                    pos_next   = pos_inc;
                    st         = ST_ACCEPT;
                end
                else
                begin
                    rej = 1'b1;
                end
            end
            PH_CR:
            begin
                if (in_byte_reg == CH_CR)
                begin
                    phase_next = PH_LF;
                    pos_next   = pos_inc;
                    st         = ST_ACCEPT;
                end
                else
                begin
                    rej = 1'b1;
                end
            end
            PH_LF:
            begin
                if (in_byte_reg == CH_LF)
                begin
                    st         = ST_END;
                    len        = pos_inc;
                    ck         = xor_reg;
                    fp         = pok_reg;
                    phase_next = PH_IDLE;
                    pos_next   = '0;
                end
                else
                begin
                    rej = 1'b1;
                end
            end
            default:
            begin
                // Hunt for the preamble.
                phase_next = PH_IDLE;
                if (in_byte_reg == CH_DOLLAR)
                begin
                    phase_next = PH_BODY;
                    pos_next   = 11'd1;
                    xor_next   = '0;
                    pm_next    = '0;
                    pok_next   = 1'b0;
                    st         = ST_ACCEPT;
                    rs         = 1'b1;
                end
            end
        endcase

        // A failing '$' opens the next sentence at once; anything else drops to idle.
        if (rej)
        begin
            st = ST_REJECT;
            if (in_byte_reg == CH_DOLLAR)
            begin
                phase_next = PH_BODY;
                pos_next   = 11'd1;
                xor_next   = '0;
                pm_next    = '0;
                pok_next   = 1'b0;
                rs         = 1'b1;
            end
            else
            begin
                phase_next = PH_IDLE;
                pos_next   = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pos_reg   <= MAX_POS_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            xor_reg       <= '0;
            pm_reg        <= '0;
            pok_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_pos_reg <= cfg.data;
            end
            if (stream.valid && stream.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                xor_reg       <= xor_next;
                pm_reg        <= pm_next;
                pok_reg       <= pok_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_byte_reg <= stream.data_byte;
        end
        if (step)
        begin
            out_status_reg    <= st;
            out_restarted_reg <= rs;
            out_length_reg    <= len;
            out_ck_reg        <= ck;
            out_fp_reg        <= fp;
        end
    end

endmodule

`default_nettype wire
